@@ src/dq_pkg.sv @@
// types and codes shared by the double-ended queue modules
// no dependencies
package dq_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 11;

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_PEEK_FRONT = 3'd4;
  localparam logic [2:0] REQ_PEEK_BACK  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]                req_type;
    logic signed [VALUE_W-1:0] push_value;
  } dq_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] item_value;
    logic [1:0]                status;
    logic [COUNT_W-1:0]        item_count;
    logic                      is_empty;
  } dq_rsp_t;

endpackage

@@ src/dq_store.sv @@
// single-port value store with registered read data
// depends on dq_pkg
module dq_store import dq_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int IDX_W = 10
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic                      re,
  input  logic [IDX_W-1:0]          addr,
  input  logic signed [VALUE_W-1:0] wdata,
  output logic signed [VALUE_W-1:0] rdata
);

  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ src/double_ended_queue.sv @@
// Bounded double-ended queue of signed 32-bit values held in one single-port
// memory of DEPTH entries, tracked by a front pointer and a count. The accept
// cycle computes the entry address and writes or launches the read; the block
// then stays busy until the output slot is free, and then moves the result
// (with the registered read data) into the output register. It takes no new
// request while busy; it is ready again once the result is loaded, even while
// that result still waits on rsp_ready. item_count carries the count in 11
// bits, so DEPTH above 2047 wraps that field.
module double_ended_queue import dq_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  dq_req_t req,
  output logic    rsp_valid,
  input  logic    rsp_ready,
  output dq_rsp_t rsp
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W:0]   DEPTH_S = (CNT_W+1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_I  = IDX_W'(DEPTH - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  logic             state;
  logic [IDX_W-1:0] front, front_next;
  logic [CNT_W-1:0] count, count_next;

  logic             pend_mem;
  logic [1:0]       pend_status;
  logic [CNT_W-1:0] pend_count;

  logic                      we, re, use_mem;
  logic [IDX_W-1:0]          addr;
  logic [1:0]                st;
  logic signed [VALUE_W-1:0] rdata;

  logic             accept, slot_free, full, empty;
  logic [IDX_W-1:0] front_dec, front_inc, back_pos, last_pos;
  logic [CNT_W:0]   sum_back, sum_last;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign slot_free = !rsp_valid || rsp_ready;
  assign full      = (count == DEPTH_C);
  assign empty     = (count == '0);

  // circular positions, sums stay below twice the depth
  assign front_dec = (front == '0) ? LAST_I : front - 1'b1;
  assign front_inc = (front == LAST_I) ? '0 : front + 1'b1;
  assign sum_back  = (CNT_W+1)'(front) + (CNT_W+1)'(count);
  assign sum_last  = sum_back - 1'b1;
  assign back_pos  = IDX_W'((sum_back >= DEPTH_S) ? sum_back - DEPTH_S : sum_back);
  assign last_pos  = IDX_W'((sum_last >= DEPTH_S) ? sum_last - DEPTH_S : sum_last);

  always_comb begin
    we         = 1'b0;
    re         = 1'b0;
    use_mem    = 1'b0;
    addr       = front;
    st         = ST_OK;
    front_next = front;
    count_next = count;
    case (req.req_type)
      REQ_PUSH_FRONT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          we         = 1'b1;
          addr       = front_dec;
          front_next = front_dec;
          count_next = count + 1'b1;
        end
      end
      REQ_PUSH_BACK: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          we         = 1'b1;
          addr       = back_pos;
          count_next = count + 1'b1;
        end
      end
      REQ_POP_FRONT, REQ_PEEK_FRONT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          re      = 1'b1;
          use_mem = 1'b1;
          addr    = front;
          if (req.req_type == REQ_POP_FRONT) begin
            front_next = front_inc;
            count_next = count - 1'b1;
          end
        end
      end
      REQ_POP_BACK, REQ_PEEK_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          re      = 1'b1;
          use_mem = 1'b1;
          addr    = last_pos;
          if (req.req_type == REQ_POP_BACK) begin
            count_next = count - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  dq_store #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (we && accept),
    .re    (re && accept),
    .addr  (addr),
    .wdata (req.push_value),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      front     <= '0;
      count     <= '0;
    end else begin
      if (state == S_BUSY && slot_free) begin
        rsp_valid <= 1'b1;
        state     <= S_IDLE;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (accept) begin
        state <= S_BUSY;
        front <= front_next;
        count <= count_next;
      end
    end
  end

  // result fields wait here for the read data
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_mem    <= use_mem;
      pend_status <= st;
      pend_count  <= count_next;
    end
    if (state == S_BUSY && slot_free) begin
      rsp.item_value <= pend_mem ? rdata : '0;
      rsp.status     <= pend_status;
      rsp.item_count <= COUNT_W'(pend_count);
      rsp.is_empty   <= (pend_count == '0);
    end
  end

endmodule

@@ sim/tb_double_ended_queue.sv @@
// testbench for double_ended_queue: directed corner requests, then random fill and drain runs
// predicts every response from its own copy of the deque; needs dq_pkg and double_ended_queue
module tb_double_ended_queue;
  import dq_pkg::*;

  localparam int DQ_DEPTH = 1024;
  localparam logic [2:0] REQ_NOP_6 = 3'd6;
  localparam logic [2:0] REQ_NOP_7 = 3'd7;
  localparam int RANDOM_REQS = 1780;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;

  logic    clk;
  logic    rst;
  logic    req_valid;
  logic    req_ready;
  dq_req_t req;
  logic    rsp_valid;
  logic    rsp_ready;
  dq_rsp_t rsp;

  double_ended_queue #(.DEPTH(DQ_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  dq_req_t pending_reqs[$];
  dq_rsp_t expected_rsps[$];

  // predicted deque contents
  logic signed [VALUE_W-1:0] shadow_vals [DQ_DEPTH];
  int unsigned shadow_head;
  int unsigned shadow_count;

  // occupancy as the request generator sees it
  int gen_count;
  int gen_full_hits;

  int total_reqs;
  int accepted_reqs;
  int accepted_rsps;
  int mismatches;
  int stall_cycles;
  int full_refusals;
  int empty_reads;
  int peak_count;
  bit req_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic dq_rsp_t deque_apply(dq_req_t r);
    dq_rsp_t o;
    int unsigned slot;
    o.item_value = '0;
    o.status = ST_OK;
    case (r.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (shadow_count == DQ_DEPTH) begin
          o.status = ST_FULL;
          full_refusals++;
        end else if (r.req_type == REQ_PUSH_FRONT) begin
          shadow_head = (shadow_head + DQ_DEPTH - 1) % DQ_DEPTH;
          shadow_vals[shadow_head] = r.push_value;
          shadow_count++;
        end else begin
          shadow_vals[(shadow_head + shadow_count) % DQ_DEPTH] = r.push_value;
          shadow_count++;
        end
      end
      REQ_POP_FRONT, REQ_PEEK_FRONT: begin
        if (shadow_count == 0) begin
          o.status = ST_EMPTY;
          empty_reads++;
        end else begin
          o.item_value = shadow_vals[shadow_head];
          if (r.req_type == REQ_POP_FRONT) begin
            shadow_head = (shadow_head + 1) % DQ_DEPTH;
            shadow_count--;
          end
        end
      end
      REQ_POP_BACK, REQ_PEEK_BACK: begin
        if (shadow_count == 0) begin
          o.status = ST_EMPTY;
          empty_reads++;
        end else begin
          slot = (shadow_head + shadow_count - 1) % DQ_DEPTH;
          o.item_value = shadow_vals[slot];
          if (r.req_type == REQ_POP_BACK) shadow_count--;
        end
      end
      default: ;
    endcase
    if (shadow_count > peak_count) peak_count = shadow_count;
    o.item_count = COUNT_W'(shadow_count);
    o.is_empty = (shadow_count == 0);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t on response %0d: %s got %0h expected %0h",
             $time, accepted_rsps, what, got, want);
    mismatches++;
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_op(int push_pct, int pop_pct, int peek_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < push_pct) return $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    if (roll < push_pct + pop_pct) return $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
    if (roll < push_pct + pop_pct + peek_pct)
      return $urandom_range(1) ? REQ_PEEK_BACK : REQ_PEEK_FRONT;
    return $urandom_range(1) ? REQ_NOP_7 : REQ_NOP_6;
  endfunction

  task automatic add_req(logic [2:0] op, logic [VALUE_W-1:0] v);
    dq_req_t r;
    r.req_type = op;
    r.push_value = v;
    pending_reqs.insert(pending_reqs.size(), r);
    if (op == REQ_PUSH_FRONT || op == REQ_PUSH_BACK) begin
      if (gen_count == DQ_DEPTH) gen_full_hits++;
      else gen_count++;
    end else if ((op == REQ_POP_FRONT || op == REQ_POP_BACK) && gen_count != 0) begin
      gen_count--;
    end
  endtask

  // idle odds move through three phases as requests are accepted
  function automatic int idle_pct(bit sender);
    if (accepted_reqs * 3 < total_reqs) return sender ? 28 : 61;
    if (accepted_reqs * 3 < total_reqs * 2) return sender ? 61 : 28;
    return 0;
  endfunction

  // driver: request and response-ready change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      rsp_ready <= 1'b0;
    end else begin
      if (!req_valid || req_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          req <= pending_reqs[0];
          pending_reqs.delete(0);
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
      rsp_ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  // monitor: check the response beat first, then predict the request beat
  always @(posedge clk) begin
    dq_rsp_t want;
    if (!rst) begin
      req_taken = req_valid && req_ready;
      if (rsp_valid && rsp_ready) begin
        accepted_rsps++;
        if (expected_rsps.size() == 0) begin
          report_mismatch("response with nothing outstanding", rsp.item_value, '0);
        end else begin
          want = expected_rsps[0];
          expected_rsps.delete(0);
          if (rsp.item_value !== want.item_value)
            report_mismatch("item_value", rsp.item_value, want.item_value);
          if (rsp.status !== want.status)
            report_mismatch("status", 32'(rsp.status), 32'(want.status));
          if (rsp.item_count !== want.item_count)
            report_mismatch("item_count", 32'(rsp.item_count), 32'(want.item_count));
          if (rsp.is_empty !== want.is_empty)
            report_mismatch("is_empty", 32'(rsp.is_empty), 32'(want.is_empty));
        end
      end
      if (req_taken) begin
        expected_rsps.insert(expected_rsps.size(), deque_apply(req));
        accepted_reqs++;
      end
      stall_cycles <= (req_taken || (rsp_valid && rsp_ready)) ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("no beat moved for %0d cycles, %0d responses still outstanding",
             STALL_LIMIT, expected_rsps.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int stage;
    int n;
    int stage_items;
    logic [2:0] op;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_ready = 1'b0;
    shadow_head = 0;
    shadow_count = 0;
    gen_count = 0;
    gen_full_hits = 0;
    accepted_reqs = 0;
    accepted_rsps = 0;
    mismatches = 0;
    stall_cycles = 0;
    full_refusals = 0;
    empty_reads = 0;
    peak_count = 0;
    req_taken = 1'b0;

    // reads and unused codes on an empty deque
    add_req(REQ_POP_FRONT, rand_value());
    add_req(REQ_POP_BACK, rand_value());
    add_req(REQ_PEEK_FRONT, rand_value());
    add_req(REQ_PEEK_BACK, rand_value());
    add_req(REQ_NOP_6, rand_value());
    add_req(REQ_NOP_7, rand_value());
    // push front from empty wraps the front pointer below zero
    add_req(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
    add_req(REQ_PUSH_BACK, 32'h8000_0000);
    add_req(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
    add_req(REQ_PUSH_BACK, 32'h0000_0000);
    add_req(REQ_PUSH_FRONT, 32'hAAAA_AAAA);
    add_req(REQ_PUSH_BACK, 32'h5555_5555);
    add_req(REQ_PEEK_FRONT, rand_value());
    add_req(REQ_PEEK_BACK, rand_value());
    add_req(REQ_NOP_6, 32'hFFFF_FFFF);
    add_req(REQ_NOP_7, 32'h1234_5678);
    // drain both ends, the sixth pop empties the deque and the last one finds it empty
    add_req(REQ_POP_FRONT, rand_value());
    add_req(REQ_POP_BACK, rand_value());
    add_req(REQ_POP_FRONT, rand_value());
    add_req(REQ_POP_BACK, rand_value());
    add_req(REQ_POP_FRONT, rand_value());
    add_req(REQ_POP_BACK, rand_value());
    add_req(REQ_POP_FRONT, rand_value());

    // mixed warm-up, fill past full, drain until empty or for 500 requests, mixed tail
    stage = 0;
    n = 0;
    stage_items = 0;
    while (!(stage == 3 && n >= RANDOM_REQS && stage_items >= 100)) begin
      case (stage)
        0: op = pick_op(40, 40, 15);
        1: op = pick_op(94, 3, 2);
        2: op = pick_op(3, 94, 2);
        default: op = pick_op(40, 40, 15);
      endcase
      add_req(op, rand_value());
      n++;
      stage_items++;
      if ((stage == 0 && stage_items >= 60) || (stage == 1 && gen_full_hits >= 16) ||
          (stage == 2 && (gen_count == 0 || stage_items >= 500))) begin
        stage++;
        stage_items = 0;
      end
    end
    total_reqs = pending_reqs.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid) @(posedge clk);
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d requests and checked %0d responses", accepted_reqs, accepted_rsps);
    $display("peak occupancy %0d of %0d, %0d pushes refused when full, %0d reads when empty",
             peak_count, DQ_DEPTH, full_refusals, empty_reads);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
